>>> hdl/msc_pkg.sv
// ----------------------------------------------------------------------------
// MCTP-over-SMBus packet checker package
// Status codes, header constants and the byte-wide SMBus PEC function.
// ----------------------------------------------------------------------------
package msc_pkg;

	localparam int HEADER_BYTES = 7;

	localparam logic [7:0] SMBUS_MCTP_CODE   = 8'h0F;
	localparam logic [3:0] SUPPORTED_VERSION = 4'h1;
	localparam logic [6:0] TYPE_CONTROL      = 7'h00;
	localparam logic [6:0] TYPE_VENDOR       = 7'h7E;
	localparam logic [8:0] POSITION_MAX      = 9'd511;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
	localparam logic [2:0] ST_INVALID   = 3'd3;
	localparam logic [2:0] ST_BAD_VER   = 3'd4;
	localparam logic [2:0] ST_BAD_PEC   = 3'd5;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ 8'h07;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

>>> hdl/mctp_smbus_packet_checker.sv
// ----------------------------------------------------------------------------
// MCTP-over-SMBus packet checker
// Parses the transport header of a received packet byte by byte, runs the
// SMBus PEC and reports the header fields and a status on the final byte.
// The final byte is held in an input register; the result is registered too.
// Throughput: one byte per cycle; a final byte waits only while an earlier
// result is stalled.
// Reset clears the byte position, PEC, held message type and both valids.
// ----------------------------------------------------------------------------
module mctp_smbus_packet_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] status,
	output logic [6:0] source_address,
	output logic       start_of_message,
	output logic       end_of_message,
	output logic [7:0] source_endpoint,
	output logic [7:0] destination_endpoint,
	output logic [7:0] payload_length,
	output logic [2:0] message_tag,
	output logic [1:0] sequence_number,
	output logic [7:0] computed_pec,
	output logic [7:0] message_type
);

	logic [6:0] own_address_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;

	logic [8:0] pos_q;
	logic [7:0] pec_q;
	logic [7:0] snap_q;
	logic [7:0] rpec_q;
	logic [7:0] held_type_q;
	logic [7:0] header_q [msc_pkg::HEADER_BYTES];

	logic       out_valid_q;
	logic [2:0] status_q;
	logic [6:0] src_addr_q;
	logic       som_q;
	logic       eom_q;
	logic [7:0] src_ep_q;
	logic [7:0] dst_ep_q;
	logic [7:0] plen_q;
	logic [2:0] tag_q;
	logic [1:0] seq_q;
	logic [7:0] cpec_q;
	logic [7:0] mtype_q;

	logic [7:0] prev_pec;
	logic [7:0] next_pec;
	logic       snap_hit;
	logic       type_hit;
	logic [7:0] snap_n;
	logic [7:0] rpec_n;
	logic [7:0] mtype_n;
	logic [8:0] pos_n;
	logic [8:0] pkt_len;
	logic       is_control;
	logic       is_vendor;
	logic       too_short;
	logic       invalid;
	logic [2:0] status_n;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		prev_pec   = (pos_q == 9'd0) ? {own_address_q, 1'b0} : pec_q;
		next_pec   = msc_pkg::crc8_byte(prev_pec, data_s1);
		snap_hit   = (pos_q >= 9'd2) && (pos_q == ({1'b0, header_q[1]} + 9'd2));
		type_hit   = (pos_q == 9'(msc_pkg::HEADER_BYTES)) && header_q[6][7]
			&& (header_q[1] > 8'(msc_pkg::HEADER_BYTES));
		snap_n     = snap_hit ? prev_pec : snap_q;
		rpec_n     = snap_hit ? data_s1 : rpec_q;
		mtype_n    = type_hit ? data_s1 : held_type_q;
		pos_n      = (pos_q < msc_pkg::POSITION_MAX) ? pos_q + 9'd1 : msc_pkg::POSITION_MAX;
		is_control = (mtype_n[6:0] == msc_pkg::TYPE_CONTROL);
		is_vendor  = (mtype_n[6:0] == msc_pkg::TYPE_VENDOR);
		pkt_len    = {1'b0, header_q[1]} + (is_vendor ? 9'd3 : 9'd2);
		too_short  = (pos_q < 9'(msc_pkg::HEADER_BYTES))
			|| (header_q[1] <= 8'(msc_pkg::HEADER_BYTES));
		invalid    = (header_q[0] != msc_pkg::SMBUS_MCTP_CODE) || (pos_n < pkt_len)
			|| (header_q[3][7:4] != 4'h0) || (header_q[4] == header_q[5]);
		if (too_short) begin
			status_n = msc_pkg::ST_SHORT;
		end else if (!is_control && !is_vendor) begin
			status_n = msc_pkg::ST_BAD_TYPE;
		end else if (invalid) begin
			status_n = msc_pkg::ST_INVALID;
		end else if (header_q[3][3:0] != msc_pkg::SUPPORTED_VERSION) begin
			status_n = msc_pkg::ST_BAD_VER;
		end else if (is_vendor && (snap_n != rpec_n)) begin
			status_n = msc_pkg::ST_BAD_PEC;
		end else begin
			status_n = msc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_we) begin
			own_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			pec_q       <= '0;
			snap_q      <= '0;
			rpec_q      <= '0;
			held_type_q <= '0;
			for (int k = 0; k < msc_pkg::HEADER_BYTES; k++) begin
				header_q[k] <= '0;
			end
		end else if (advance) begin
			for (int k = 0; k < msc_pkg::HEADER_BYTES; k++) begin
				if (pos_q == 9'(k)) begin
					header_q[k] <= data_s1;
				end
			end
			snap_q      <= snap_n;
			rpec_q      <= rpec_n;
			held_type_q <= mtype_n;
			if (last_s1) begin
				pos_q <= '0;
				pec_q <= '0;
			end else begin
				pos_q <= pos_n;
				pec_q <= next_pec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_n;
			if (too_short) begin
				src_addr_q <= '0;
				som_q      <= 1'b0;
				eom_q      <= 1'b0;
				src_ep_q   <= '0;
				dst_ep_q   <= '0;
				plen_q     <= '0;
				tag_q      <= '0;
				seq_q      <= '0;
				mtype_q    <= '0;
			end else begin
				src_addr_q <= header_q[2][7:1];
				som_q      <= header_q[6][7];
				eom_q      <= header_q[6][6];
				src_ep_q   <= header_q[5];
				dst_ep_q   <= header_q[4];
				plen_q     <= header_q[1] - 8'd5;
				tag_q      <= header_q[6][2:0];
				seq_q      <= header_q[6][5:4];
				mtype_q    <= mtype_n;
			end
			if ((status_n == msc_pkg::ST_OK || status_n == msc_pkg::ST_BAD_PEC) && is_vendor) begin
				cpec_q <= snap_n;
			end else begin
				cpec_q <= '0;
			end
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = status_q;
	assign source_address       = src_addr_q;
	assign start_of_message     = som_q;
	assign end_of_message       = eom_q;
	assign source_endpoint      = src_ep_q;
	assign destination_endpoint = dst_ep_q;
	assign payload_length       = plen_q;
	assign message_tag          = tag_q;
	assign sequence_number      = seq_q;
	assign computed_pec         = cpec_q;
	assign message_type         = mtype_q;

endmodule

>>> hdl/msc_checker.sv
// ----------------------------------------------------------------------------
// MCTP-over-SMBus packet checker assertions
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module msc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [6:0] source_address,
	input logic       start_of_message,
	input logic       end_of_message,
	input logic [7:0] source_endpoint,
	input logic [7:0] destination_endpoint,
	input logic [7:0] payload_length,
	input logic [2:0] message_tag,
	input logic [1:0] sequence_number,
	input logic [7:0] computed_pec,
	input logic [7:0] message_type
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(computed_pec))
		else $error("Result changed while stalled.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= msc_pkg::ST_BAD_PEC)
		else $error("Status code out of range.");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == msc_pkg::ST_SHORT |-> source_address == 7'd0
		&& !start_of_message && !end_of_message && source_endpoint == 8'd0
		&& destination_endpoint == 8'd0 && payload_length == 8'd0 && message_tag == 3'd0
		&& sequence_number == 2'd0 && computed_pec == 8'd0 && message_type == 8'd0)
		else $error("Short packet result carries nonzero fields.");

	a_pec_only_checked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && computed_pec != 8'd0
		|-> status == msc_pkg::ST_OK || status == msc_pkg::ST_BAD_PEC)
		else $error("PEC reported for a packet that was not checked.");

	a_length_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != msc_pkg::ST_SHORT
		|-> payload_length >= 8'd3 && payload_length <= 8'd250)
		else $error("Payload length out of range.");

endmodule

bind mctp_smbus_packet_checker msc_checker u_msc_checker (.*);

>>> dv/mctp_smbus_report_checker.sv
// ----------------------------------------------------------------------------
// MCTP-over-SMBus packet report checker
// Watches the byte and report channels of the packet checker, keeps its own
// copy of the header, PEC and message-type state, predicts one report per
// final byte and compares every report field against the oldest prediction.
// ----------------------------------------------------------------------------
module mctp_smbus_report_checker
	import msc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [2:0] status,
	input  logic [6:0] source_address,
	input  logic       start_of_message,
	input  logic       end_of_message,
	input  logic [7:0] source_endpoint,
	input  logic [7:0] destination_endpoint,
	input  logic [7:0] payload_length,
	input  logic [2:0] message_tag,
	input  logic [1:0] sequence_number,
	input  logic [7:0] computed_pec,
	input  logic [7:0] message_type,
	output int         mismatches,
	output int         outstanding,
	output int         reports_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] src_addr;
		logic       som;
		logic       eom;
		logic [7:0] src_ep;
		logic [7:0] dst_ep;
		logic [7:0] pay_len;
		logic [2:0] tag;
		logic [1:0] seq;
		logic [7:0] pec;
		logic [7:0] mtype;
	} report_t;

	logic [6:0] own_addr;
	logic [8:0] position;
	logic [7:0] crc_run;
	logic [7:0] crc_snap;
	logic [7:0] crc_rx;
	logic [7:0] held_type;
	logic [7:0] hdr [HEADER_BYTES];
	report_t    awaited_reports [$];

	initial begin
		mismatches = 0;
		reports_checked = 0;
		outstanding = 0;
	end

	function automatic logic [7:0] pec_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
		end
		return c;
	endfunction

	task automatic absorb_byte(input logic [7:0] b, input logic fin);
		logic [8:0] idx;
		logic [8:0] count;
		logic [8:0] need;
		logic [7:0] seed;
		logic [7:0] bc;
		logic       is_ctl;
		logic       is_vnd;
		report_t    r;
		idx = position;
		seed = (idx == 9'd0) ? {own_addr, 1'b0} : crc_run;
		if (idx < HEADER_BYTES) begin
			hdr[idx[2:0]] = b;
		end
		if (idx >= 9'd2 && idx == {1'b0, hdr[1]} + 9'd2) begin
			crc_snap = seed;
			crc_rx = b;
		end
		if (idx == HEADER_BYTES && hdr[6][7] && hdr[1] > HEADER_BYTES) begin
			held_type = b;
		end
		crc_run = pec_update(seed, b);
		position = (idx < POSITION_MAX) ? idx + 9'd1 : POSITION_MAX;
		if (fin) begin
			count = position;
			position = '0;
			crc_run = '0;
			r = '0;
			bc = hdr[1];
			if (count <= HEADER_BYTES || bc <= HEADER_BYTES) begin
				r.status = ST_SHORT;
			end else begin
				r.src_addr = hdr[2][7:1];
				r.som = hdr[6][7];
				r.eom = hdr[6][6];
				r.src_ep = hdr[5];
				r.dst_ep = hdr[4];
				r.pay_len = bc - 8'd5;
				r.tag = hdr[6][2:0];
				r.seq = hdr[6][5:4];
				r.mtype = held_type;
				is_ctl = (held_type[6:0] == TYPE_CONTROL);
				is_vnd = (held_type[6:0] == TYPE_VENDOR);
				if (!is_ctl && !is_vnd) begin
					r.status = ST_BAD_TYPE;
				end else begin
					need = {1'b0, bc} + (is_vnd ? 9'd3 : 9'd2);
					if (hdr[0] != SMBUS_MCTP_CODE || count < need ||
						hdr[3][7:4] != 4'h0 || hdr[4] == hdr[5]) begin
						r.status = ST_INVALID;
					end else if (hdr[3][3:0] != SUPPORTED_VERSION) begin
						r.status = ST_BAD_VER;
					end else if (is_vnd) begin
						r.pec = crc_snap;
						r.status = (crc_snap != crc_rx) ? ST_BAD_PEC : ST_OK;
					end else begin
						r.status = ST_OK;
					end
				end
			end
			awaited_reports.push_back(r);
		end
	endtask

	task automatic compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		report_t r;
		if (!arst_n) begin
			own_addr = '0;
			position = '0;
			crc_run = '0;
			crc_snap = '0;
			crc_rx = '0;
			held_type = '0;
			for (int i = 0; i < HEADER_BYTES; i++) begin
				hdr[i] = '0;
			end
			awaited_reports.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				own_addr = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					$display("%0t: report transfer with none expected, actual status %0h",
						$time, status);
					mismatches++;
				end else begin
					r = awaited_reports.pop_front();
					reports_checked++;
					compare_field("status", 8'(r.status), 8'(status));
					compare_field("source_address", 8'(r.src_addr), 8'(source_address));
					compare_field("start_of_message", 8'(r.som), 8'(start_of_message));
					compare_field("end_of_message", 8'(r.eom), 8'(end_of_message));
					compare_field("source_endpoint", r.src_ep, source_endpoint);
					compare_field("destination_endpoint", r.dst_ep, destination_endpoint);
					compare_field("payload_length", r.pay_len, payload_length);
					compare_field("message_tag", 8'(r.tag), 8'(message_tag));
					compare_field("sequence_number", 8'(r.seq), 8'(sequence_number));
					compare_field("computed_pec", r.pec, computed_pec);
					compare_field("message_type", r.mtype, message_type);
				end
			end
			if (in_valid && in_ready) begin
				absorb_byte(data_byte, last_byte);
			end
			outstanding <= awaited_reports.size();
		end
	end

endmodule

>>> dv/tb_mctp_smbus_packet_checker.sv
// ----------------------------------------------------------------------------
// MCTP-over-SMBus packet checker testbench
// Sends directed packets, then random multi-packet messages of control,
// vendor and unsupported types with injected header, length and PEC faults,
// under random sender gaps and receiver stalls and several own addresses.
// ----------------------------------------------------------------------------
module tb_mctp_smbus_packet_checker;
	timeunit 1ns;
	timeprecision 1ps;

	import msc_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int BYTE_TARGET = 1350;
	localparam int MAX_WAIT    = 17;

	typedef enum int {
		FL_NONE,
		FL_CMD,
		FL_RESERVED,
		FL_VERSION,
		FL_SAME_EP,
		FL_PEC,
		FL_TRUNCATE,
		FL_EXTRA,
		FL_SHORT_COUNT,
		FL_BIG_COUNT,
		FL_TYPE,
		FL_NOISE
	} flaw_e;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] status;
	logic [6:0] source_address;
	logic       start_of_message;
	logic       end_of_message;
	logic [7:0] source_endpoint;
	logic [7:0] destination_endpoint;
	logic [7:0] payload_length;
	logic [2:0] message_tag;
	logic [1:0] sequence_number;
	logic [7:0] computed_pec;
	logic [7:0] message_type;

	int         mismatches;
	int         outstanding;
	int         reports_checked;
	int         cycle_count;
	int         bytes_sent;
	int         packets_sent;
	int         settings_used;
	bit         tx_quiet;
	logic [6:0] cur_addr;
	logic [7:0] pkt_bytes [$];

	mctp_smbus_packet_checker u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.data_byte           (data_byte),
		.last_byte           (last_byte),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.status              (status),
		.source_address      (source_address),
		.start_of_message    (start_of_message),
		.end_of_message      (end_of_message),
		.source_endpoint     (source_endpoint),
		.destination_endpoint(destination_endpoint),
		.payload_length      (payload_length),
		.message_tag         (message_tag),
		.sequence_number     (sequence_number),
		.computed_pec        (computed_pec),
		.message_type        (message_type)
	);

	mctp_smbus_report_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.data_byte           (data_byte),
		.last_byte           (last_byte),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.status              (status),
		.source_address      (source_address),
		.start_of_message    (start_of_message),
		.end_of_message      (end_of_message),
		.source_endpoint     (source_endpoint),
		.destination_endpoint(destination_endpoint),
		.payload_length      (payload_length),
		.message_tag         (message_tag),
		.sequence_number     (sequence_number),
		.computed_pec        (computed_pec),
		.message_type        (message_type),
		.mismatches          (mismatches),
		.outstanding         (outstanding),
		.reports_checked     (reports_checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_packet();
		foreach (pkt_bytes[i]) begin
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
		end
		packets_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_address(input logic [6:0] a);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_addr = a;
		settings_used++;
	endtask

	function automatic void build_packet(input int bc, input bit som, input bit eom,
		input logic [7:0] mtype, input bit with_pec);
		logic [7:0] s_ep;
		logic [7:0] d_ep;
		logic [7:0] crc;
		d_ep = 8'($urandom);
		s_ep = 8'($urandom);
		if (s_ep == d_ep) begin
			s_ep = ~d_ep;
		end
		pkt_bytes.delete();
		pkt_bytes.push_back(SMBUS_MCTP_CODE);
		pkt_bytes.push_back(8'(bc));
		pkt_bytes.push_back(8'($urandom));
		pkt_bytes.push_back({4'h0, SUPPORTED_VERSION});
		pkt_bytes.push_back(d_ep);
		pkt_bytes.push_back(s_ep);
		pkt_bytes.push_back({som, eom, 6'($urandom)});
		for (int i = HEADER_BYTES; i <= bc + 1; i++) begin
			pkt_bytes.push_back((i == HEADER_BYTES && som) ? mtype : 8'($urandom));
		end
		if (with_pec) begin
			crc = {cur_addr, 1'b0};
			foreach (pkt_bytes[i]) begin
				crc = crc8_byte(crc, pkt_bytes[i]);
			end
			pkt_bytes.push_back(crc);
		end
	endfunction

	function automatic void apply_flaw(input flaw_e f);
		int v;
		case (f)
			FL_CMD: begin
				pkt_bytes[0] = pkt_bytes[0] ^ 8'($urandom_range(1, 255));
			end
			FL_RESERVED: begin
				pkt_bytes[3] = {4'($urandom_range(1, 15)), pkt_bytes[3][3:0]};
			end
			FL_VERSION: begin
				v = $urandom_range(0, 14);
				if (v >= 1) begin
					v++;
				end
				pkt_bytes[3] = {pkt_bytes[3][7:4], 4'(v)};
			end
			FL_SAME_EP: begin
				pkt_bytes[5] = pkt_bytes[4];
			end
			FL_PEC: begin
				pkt_bytes[pkt_bytes.size() - 1] =
					pkt_bytes[pkt_bytes.size() - 1] ^ 8'($urandom_range(1, 255));
			end
			FL_TRUNCATE: begin
				repeat ($urandom_range(1, pkt_bytes.size() - 1)) void'(pkt_bytes.pop_back());
			end
			FL_EXTRA: begin
				repeat ($urandom_range(1, 6)) pkt_bytes.push_back(8'($urandom));
			end
			FL_SHORT_COUNT: begin
				pkt_bytes[1] = 8'($urandom_range(0, HEADER_BYTES));
			end
			FL_BIG_COUNT: begin
				pkt_bytes[1] = 8'($urandom_range(HEADER_BYTES + 1, 255));
			end
			FL_TYPE: begin
				pkt_bytes[HEADER_BYTES] = 8'($urandom);
			end
			FL_NOISE: begin
				pkt_bytes.delete();
				repeat ($urandom_range(1, 24)) pkt_bytes.push_back(8'($urandom));
			end
			default: begin
			end
		endcase
	endfunction

	task automatic run_packet(input int bc, input bit som, input bit eom,
		input logic [7:0] mtype, input flaw_e f);
		build_packet(bc, som, eom, mtype, mtype[6:0] == TYPE_VENDOR);
		apply_flaw(f);
		send_packet();
	endtask

	function automatic logic [7:0] pick_type(input int kind);
		logic [7:0] t;
		case (kind)
			0: t = {1'($urandom), TYPE_CONTROL};
			1: t = {1'($urandom), TYPE_VENDOR};
			default: begin
				t = 8'($urandom);
				if (t[6:0] == TYPE_CONTROL || t[6:0] == TYPE_VENDOR) begin
					t[3] = ~t[3];
				end
			end
		endcase
		return t;
	endfunction

	initial begin
		int stall;
		int calm_left;
		calm_left = 0;
		out_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (calm_left > 0) begin
				stall = 0;
				calm_left--;
			end else begin
				stall = $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 11) == 0) begin
					calm_left = 12;
				end
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int         kind;
		int         count;
		int         next_setting_at;
		bit         long_done;
		logic [7:0] mt;
		flaw_e      f;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		cur_addr = '0;
		bytes_sent = 0;
		packets_sent = 0;
		settings_used = 1;
		tx_quiet = 1'b0;
		long_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_packet(8, 1'b1, 1'b1, 8'h00, FL_NONE);
		run_packet(8, 1'b1, 1'b0, 8'h7E, FL_NONE);
		write_address(7'h7F);
		run_packet(9, 1'b1, 1'b0, 8'hFE, FL_NONE);
		run_packet(10, 1'b0, 1'b1, 8'hFE, FL_NONE);
		run_packet(8, 1'b1, 1'b1, 8'h80, FL_NONE);
		build_packet(8, 1'b1, 1'b1, 8'h00, 1'b0);
		pkt_bytes[2] = 8'hFF;
		pkt_bytes[4] = 8'h00;
		pkt_bytes[5] = 8'hFF;
		pkt_bytes[6] = 8'hFF;
		send_packet();
		build_packet(8, 1'b0, 1'b0, 8'h00, 1'b0);
		pkt_bytes[2] = 8'h00;
		pkt_bytes[4] = 8'h00;
		pkt_bytes[5] = 8'h01;
		pkt_bytes[6] = 8'h00;
		send_packet();
		pkt_bytes.delete();
		pkt_bytes.push_back(SMBUS_MCTP_CODE);
		pkt_bytes.push_back(8'h08);
		pkt_bytes.push_back(8'h10);
		send_packet();
		run_packet(8, 1'b1, 1'b1, 8'h00, FL_SHORT_COUNT);
		run_packet(8, 1'b1, 1'b1, 8'h05, FL_NONE);
		run_packet(8, 1'b1, 1'b1, 8'h00, FL_CMD);
		run_packet(8, 1'b1, 1'b1, 8'h00, FL_RESERVED);
		run_packet(8, 1'b1, 1'b1, 8'h00, FL_SAME_EP);
		run_packet(8, 1'b1, 1'b1, 8'h7E, FL_VERSION);
		run_packet(8, 1'b1, 1'b1, 8'h7E, FL_PEC);
		run_packet(9, 1'b1, 1'b1, 8'h7E, FL_TRUNCATE);
		run_packet(8, 1'b1, 1'b1, 8'h7E, FL_EXTRA);
		write_address(7'h00);
		run_packet(8, 1'b1, 1'b1, 8'hFE, FL_NONE);

		next_setting_at = bytes_sent + 300;
		while (bytes_sent < BYTE_TARGET) begin
			if (bytes_sent >= next_setting_at) begin
				case (settings_used % 3)
					0: write_address(7'h7F);
					1: write_address(7'h00);
					default: write_address(7'($urandom));
				endcase
				next_setting_at += 300;
			end
			if (!long_done && bytes_sent > BYTE_TARGET / 2) begin
				build_packet(255, 1'b1, 1'b1, 8'h7E, 1'b1);
				repeat (280) pkt_bytes.push_back(8'($urandom));
				send_packet();
				long_done = 1'b1;
			end
			tx_quiet = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			mt = pick_type(kind < 4 ? 0 : (kind < 8 ? 1 : 2));
			count = $urandom_range(1, 4);
			for (int p = 0; p < count; p++) begin
				if (kind == 9) begin
					f = FL_NOISE;
				end else if ($urandom_range(0, 9) < 7) begin
					f = FL_NONE;
				end else begin
					f = flaw_e'($urandom_range(FL_CMD, FL_NOISE));
				end
				run_packet(($urandom_range(0, 39) == 0) ? $urandom_range(21, 255) :
					$urandom_range(8, 20), p == 0, p == count - 1, mt, f);
			end
			if ($urandom_range(0, 15) == 0) begin
				drain();
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d packets in %0d bytes over %0d own-address settings",
			packets_sent, bytes_sent, settings_used);
		$display("%0d reports compared, %0d mismatches", reports_checked, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
